### src/mbap_pkg.sv
// ----------------------------------------------------------------------------
// MBAP receiver package
// Shared types and constants for the Modbus TCP header deframer.
// ----------------------------------------------------------------------------
package mbap_pkg;

  localparam int unsigned HEADER_BYTES = 7;
  localparam int unsigned PDU_LIMIT    = 253;

  localparam int unsigned POS_W = 9;

  typedef enum logic [1:0] {
    CMD_BYTE    = 2'd0,
    CMD_REQUEST = 2'd1,
    CMD_TIMEOUT = 2'd2,
    CMD_CLOSE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_PDU_BYTE     = 3'd0,
    ST_REQ_ISSUED   = 3'd1,
    ST_TIMEOUT_IDLE = 3'd2,
    ST_CLOSED_IDLE  = 3'd3,
    ST_BAD_PROTOCOL = 3'd4,
    ST_BAD_LENGTH   = 3'd5,
    ST_BROKEN_FRAME = 3'd6,
    ST_UNKNOWN_TID  = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    REG_CLIENT_MODE  = 2'd0,
    REG_MIN_RESP_LEN = 2'd1,
    REG_MIN_REQ_LEN  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  pdu_byte;
    logic        is_last;
    logic [7:0]  unit_id;
    logic [7:0]  pdu_length;
    logic [15:0] xact_id;
  } out_item_t;

  typedef struct packed {
    logic       client_mode;
    logic [7:0] min_response_len;
    logic [7:0] min_request_len;
  } mbap_cfg_t;

endpackage

### src/mbap_rx_core.sv
// ----------------------------------------------------------------------------
// MBAP receive core
// Frame state, header decode and PDU forwarding, one input item per cycle while accept is high.
// ----------------------------------------------------------------------------
module mbap_rx_core
  import mbap_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  in_item_t  item,
  input  mbap_cfg_t cfg,
  output logic      res_valid,
  output out_item_t res
);

  localparam logic [POS_W-1:0] HDR_LAST  = POS_W'(HEADER_BYTES - 1);
  localparam logic [POS_W-1:0] HDR_BYTES = POS_W'(HEADER_BYTES);
  localparam logic [15:0]      LEN_MAX   = 16'(PDU_LIMIT + 1);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [47:0]      shift_r, shift_nxt;
  logic [15:0]      tid_r, tid_nxt;
  logic [7:0]       unit_r, unit_nxt;
  logic [7:0]       len_r, len_nxt;
  logic             discard_r, discard_nxt;

  logic [15:0]      hdr_tid;
  logic [15:0]      hdr_proto;
  logic [15:0]      hdr_len;
  logic [7:0]       min_len;
  logic [8:0]       min_total;
  logic [15:0]      tid_age;
  logic [POS_W-1:0] frame_end;
  logic [POS_W-1:0] pos_inc;
  logic             is_last;

  assign hdr_tid   = shift_r[47:32];
  assign hdr_proto = shift_r[31:16];
  assign hdr_len   = shift_r[15:0];
  assign tid_age   = tid_r - hdr_tid;
  assign pos_inc   = pos_r + POS_W'(1);
  assign frame_end = HDR_BYTES + POS_W'(len_r);
  assign is_last   = (pos_inc >= frame_end);

  always_comb begin
    min_len = cfg.client_mode ? cfg.min_response_len : cfg.min_request_len;
    if (min_len == 8'd0) begin
      min_len = 8'd1;
    end
    min_total = {1'b0, min_len} + 9'd1;
  end

  always_comb begin
    pos_nxt     = pos_r;
    shift_nxt   = shift_r;
    tid_nxt     = tid_r;
    unit_nxt    = unit_r;
    len_nxt     = len_r;
    discard_nxt = discard_r;
    res_valid   = 1'b0;
    res.status   = ST_PDU_BYTE;
    res.pdu_byte = 8'd0;
    res.is_last  = 1'b0;
    if (accept) begin
      unique case (item.cmd)
        CMD_REQUEST: begin
          if (cfg.client_mode) begin
            tid_nxt    = tid_r + 16'd1;
            res_valid  = 1'b1;
            res.status = ST_REQ_ISSUED;
          end
        end
        CMD_TIMEOUT, CMD_CLOSE: begin
          res_valid = 1'b1;
          if (pos_r == '0) begin
            res.status = (item.cmd == CMD_TIMEOUT) ? ST_TIMEOUT_IDLE : ST_CLOSED_IDLE;
          end else begin
            res.status  = ST_BROKEN_FRAME;
            pos_nxt     = '0;
            discard_nxt = 1'b0;
          end
        end
        default: begin
          if (pos_r < HDR_LAST) begin
            shift_nxt = {shift_r[39:0], item.rx_byte};
            pos_nxt   = pos_inc;
          end else if (pos_r == HDR_LAST) begin
            // Last header byte carries the unit id; the header is decided here.
            if (hdr_proto != 16'd0) begin
              res_valid   = 1'b1;
              res.status  = ST_BAD_PROTOCOL;
              pos_nxt     = '0;
              discard_nxt = 1'b0;
            end else if (hdr_len < {7'd0, min_total} || hdr_len > LEN_MAX) begin
              res_valid   = 1'b1;
              res.status  = ST_BAD_LENGTH;
              pos_nxt     = '0;
              discard_nxt = 1'b0;
            end else if (cfg.client_mode && hdr_tid != tid_r && tid_age[15]) begin
              res_valid   = 1'b1;
              res.status  = ST_UNKNOWN_TID;
              pos_nxt     = '0;
              discard_nxt = 1'b0;
            end else begin
              // An older id in client mode is consumed without forwarding.
              discard_nxt = cfg.client_mode && (hdr_tid != tid_r);
              if (!cfg.client_mode) begin
                tid_nxt = hdr_tid;
              end
              unit_nxt = item.rx_byte;
              len_nxt  = hdr_len[7:0] - 8'd1;
              pos_nxt  = HDR_BYTES;
            end
          end else begin
            if (is_last) begin
              pos_nxt     = '0;
              discard_nxt = 1'b0;
            end else begin
              pos_nxt = pos_inc;
            end
            if (!discard_r) begin
              res_valid    = 1'b1;
              res.status   = ST_PDU_BYTE;
              res.pdu_byte = item.rx_byte;
              res.is_last  = is_last;
            end
          end
        end
      endcase
    end
    res.unit_id    = unit_nxt;
    res.pdu_length = len_nxt;
    res.xact_id    = tid_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      tid_r     <= '0;
      unit_r    <= '0;
      len_r     <= '0;
      discard_r <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      tid_r     <= tid_nxt;
      unit_r    <= unit_nxt;
      len_r     <= len_nxt;
      discard_r <= discard_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
  end

endmodule

### src/mbap_frame_receiver.sv
// ----------------------------------------------------------------------------
// MBAP frame receiver
// Modbus TCP header deframer with transaction id tracking.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one command per transfer: a received stream
//   byte, a new-request event, a receive timeout or a peer close. The out_
//   channel returns at most one status item per input transfer: a PDU byte
//   with unit id and last flag, or an event or error report. Header bytes
//   and bytes of a stale response produce nothing.
//   Results are registered in the output register or the skid buffer.
//   Throughput is one item per cycle while in_ready is high; the limit is
//   the frame state update, a single registered pass per byte.
//   An output register plus a one-entry skid buffer separate the channels,
//   so in_ready stays high while one result waits; it drops only when both
//   entries are full, and rises again once the receiver takes a result.
//   The cfg_ port writes client mode and the minimum PDU lengths; write only
//   while the block is idle. Reset (synchronous, rst_n low) places the
//   receiver at a frame boundary with transaction id zero, client mode on,
//   minimum response length two and minimum request length one.
// ----------------------------------------------------------------------------
module mbap_frame_receiver
  import mbap_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  mbap_cfg_t cfg_r;
  logic      in_ready_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  logic      skid_valid_r;
  out_item_t skid_data_r;

  logic      accept;
  logic      pop;
  logic      core_res_valid;
  out_item_t core_res;

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign accept    = in_valid && in_ready_r;
  assign pop       = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.client_mode      <= 1'b1;
      cfg_r.min_response_len <= 8'd2;
      cfg_r.min_request_len  <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CLIENT_MODE:  cfg_r.client_mode      <= cfg_wdata[0];
        REG_MIN_RESP_LEN: cfg_r.min_response_len <= cfg_wdata;
        REG_MIN_REQ_LEN:  cfg_r.min_request_len  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mbap_rx_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_data),
    .cfg       (cfg_r),
    .res_valid (core_res_valid),
    .res       (core_res)
  );

  // Output register with a one-entry skid buffer behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
      in_ready_r   <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        if (pop) begin
          skid_valid_r <= 1'b0;
          in_ready_r   <= 1'b1;
        end
      end else if (core_res_valid) begin
        if (!out_valid_r || pop) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
          in_ready_r   <= 1'b0;
        end
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
      if (!skid_valid_r && !(core_res_valid && out_valid_r && !pop)) begin
        in_ready_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (core_res_valid) begin
      if (!out_valid_r || pop) begin
        out_data_r <= core_res;
      end else begin
        skid_data_r <= core_res;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register is empty");

  a_no_result_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(core_res_valid && skid_valid_r))
    else $error("result produced while both output entries are full");

  a_last_only_on_pdu: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.is_last) |-> (out_data_r.status == ST_PDU_BYTE))
    else $error("last flag set on a non-PDU result");

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// MBAP frame receiver testbench
// Drives byte streams, requests and link events into the deframer. Each
// command is run through a local model of the receiver when its transfer
// happens. Every status report that comes back is compared field by field
// with the oldest report still owed. The run covers client and server mode
// and several minimum PDU lengths, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import mbap_pkg::*;

  // Longest quiet stretch of a correct run is a long sender gap plus a long
  // receiver stall plus a setting change.
  localparam int QUIET_LIMIT = 2000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_wdata = '0;

  mbap_frame_receiver uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver state as the model sees it, starting from the reset values.
  int unsigned rx_pos = 0;
  logic [47:0] hdr_shift = '0;
  logic [15:0] cur_tid = '0;
  logic [7:0]  unit_reg = '0;
  logic [7:0]  pdu_len_reg = '0;
  bit          drop_frame = 1'b0;
  bit          mode_client = 1'b1;
  logic [7:0]  min_resp = 8'd2;
  logic [7:0]  min_req = 8'd1;

  in_item_t  cmd_fifo [$];
  out_item_t owed_reports [$];
  out_item_t next_report;

  // Transaction id as the stimulus side expects it once all queued commands run.
  logic [15:0] gen_tid = '0;

  int queued_items = 0;
  int cmds_sent = 0;
  int results_checked = 0;
  int frames_done = 0;
  int error_count = 0;
  int phases_run = 0;
  int status_seen [8];
  int send_gap = 0;
  int send_calm = 0;
  int take_stall = 0;
  int take_calm = 0;
  int quiet_cycles = 0;

  function automatic bit deframe_step(input in_item_t it, output out_item_t res);
    logic [15:0] hdr_tid;
    logic [15:0] hdr_proto;
    logic [15:0] hdr_len;
    logic [15:0] age;
    int unsigned minl;
    bit produces;
    res = '0;
    produces = 1'b1;
    case (it.cmd)
      CMD_REQUEST: begin
        if (mode_client) begin
          cur_tid = cur_tid + 16'd1;
          res.status = ST_REQ_ISSUED;
        end else begin
          produces = 1'b0;
        end
      end
      CMD_TIMEOUT, CMD_CLOSE: begin
        if (rx_pos == 0) begin
          res.status = (it.cmd == CMD_TIMEOUT) ? ST_TIMEOUT_IDLE : ST_CLOSED_IDLE;
        end else begin
          rx_pos = 0;
          drop_frame = 1'b0;
          res.status = ST_BROKEN_FRAME;
        end
      end
      CMD_BYTE: begin
        if (rx_pos < HEADER_BYTES - 1) begin
          hdr_shift = {hdr_shift[39:0], it.rx_byte};
          rx_pos++;
          produces = 1'b0;
        end else if (rx_pos == HEADER_BYTES - 1) begin
          hdr_tid = hdr_shift[47:32];
          hdr_proto = hdr_shift[31:16];
          hdr_len = hdr_shift[15:0];
          minl = mode_client ? min_resp : min_req;
          if (minl == 0) minl = 1;
          age = cur_tid - hdr_tid;
          if (hdr_proto != 16'd0) begin
            rx_pos = 0;
            drop_frame = 1'b0;
            res.status = ST_BAD_PROTOCOL;
          end else if (hdr_len < minl + 1 || hdr_len > PDU_LIMIT + 1) begin
            rx_pos = 0;
            drop_frame = 1'b0;
            res.status = ST_BAD_LENGTH;
          end else if (mode_client && hdr_tid != cur_tid && age >= 16'h8000) begin
            rx_pos = 0;
            drop_frame = 1'b0;
            res.status = ST_UNKNOWN_TID;
          end else begin
            // An older id in client mode means a late response: swallow it.
            drop_frame = mode_client && hdr_tid != cur_tid;
            if (!mode_client) cur_tid = hdr_tid;
            unit_reg = it.rx_byte;
            pdu_len_reg = 8'(hdr_len - 16'd1);
            rx_pos = HEADER_BYTES;
            produces = 1'b0;
          end
        end else begin
          res.status = ST_PDU_BYTE;
          res.pdu_byte = it.rx_byte;
          res.is_last = (rx_pos + 1 >= HEADER_BYTES + pdu_len_reg);
          produces = !drop_frame;
          if (res.is_last) begin
            rx_pos = 0;
            drop_frame = 1'b0;
          end else begin
            rx_pos++;
          end
        end
      end
    endcase
    res.unit_id = unit_reg;
    res.pdu_length = pdu_len_reg;
    res.xact_id = cur_tid;
    return produces;
  endfunction

  task automatic flag_mismatch(input string msg);
    error_count++;
    if (error_count <= 40) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want)
      flag_mismatch($sformatf("report %0d, %s: got %0h, expected %0h",
                              results_checked, name, got, want));
  endtask

  task automatic check_report(input out_item_t got);
    out_item_t want;
    if (owed_reports.size() == 0) begin
      flag_mismatch($sformatf("report with status %0d while none was owed", got.status));
      return;
    end
    want = owed_reports.pop_front();
    results_checked++;
    status_seen[want.status]++;
    if (want.status == ST_PDU_BYTE && want.is_last) frames_done++;
    compare_field("status", got.status, want.status);
    compare_field("pdu_byte", got.pdu_byte, want.pdu_byte);
    compare_field("is_last", got.is_last, want.is_last);
    compare_field("unit_id", got.unit_id, want.unit_id);
    compare_field("pdu_length", got.pdu_length, want.pdu_length);
    compare_field("xact_id", got.xact_id, want.xact_id);
  endtask

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int next_send_gap();
    if (send_calm > 0) begin
      send_calm--;
      return 0;
    end
    if ($urandom_range(0, 59) == 0) send_calm = $urandom_range(20, 120);
    return pick_idle();
  endfunction

  // Sender: one command per transfer, fed from the command FIFO.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        cmds_sent++;
        if (deframe_step(in_data, next_report)) owed_reports.push_back(next_report);
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (cmd_fifo.size() > 0) begin
          in_data <= cmd_fifo.pop_front();
          in_valid <= 1'b1;
          send_gap = next_send_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver side: random stalls, with calm stretches of steady readiness.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_report(out_data);
      if (take_stall > 0) begin
        take_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (take_calm > 0) take_calm--;
        else if ($urandom_range(0, 99) < 25) take_stall = pick_idle() + 1;
        else if ($urandom_range(0, 149) == 0) take_calm = $urandom_range(30, 150);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && !(in_valid && in_ready) && !(out_valid && out_ready)) quiet_cycles++;
    else quiet_cycles = 0;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("No transfer for %0d cycles, %0d reports still owed.",
               QUIET_LIMIT, owed_reports.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic push_item(input cmd_t c, input logic [7:0] b);
    in_item_t it;
    it.cmd = c;
    it.rx_byte = b;
    cmd_fifo.push_back(it);
    queued_items++;
    if (c == CMD_REQUEST && mode_client) gen_tid = gen_tid + 16'd1;
  endtask

  // Queues the first n_bytes of a frame; the PDU bytes are random. With
  // mid_req set, a request may slip in between PDU bytes.
  task automatic queue_frame(input logic [15:0] tid, input logic [15:0] proto,
                             input logic [15:0] len, input logic [7:0] unit_byte,
                             input int n_bytes, input bit mid_req);
    logic [55:0] hdr;
    hdr = {tid, proto, len, unit_byte};
    for (int i = 0; i < n_bytes; i++) begin
      if (i < HEADER_BYTES) begin
        push_item(CMD_BYTE, hdr[8 * (6 - i) +: 8]);
      end else begin
        if (mid_req && $urandom_range(0, 39) == 0) push_item(CMD_REQUEST, 8'($urandom));
        push_item(CMD_BYTE, 8'($urandom));
      end
    end
  endtask

  function automatic int min_pdu();
    int m;
    m = mode_client ? min_resp : min_req;
    return (m == 0) ? 1 : m;
  endfunction

  function automatic int pick_pdu(input int lo);
    if ($urandom_range(0, 15) == 0) return $urandom_range(lo, PDU_LIMIT);
    return $urandom_range(lo, (lo + 7 > PDU_LIMIT) ? PDU_LIMIT : lo + 7);
  endfunction

  function automatic int pick_offset(input int top);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 1;
    if (r == 1) return top;
    return $urandom_range(1, top);
  endfunction

  function automatic cmd_t link_event();
    return ($urandom_range(0, 1) != 0) ? CMD_TIMEOUT : CMD_CLOSE;
  endfunction

  task automatic queue_random_burst();
    int sel;
    int pdu;
    int minl;
    int n;
    logic [15:0] len;
    logic [15:0] tid;
    minl = min_pdu();
    pdu = pick_pdu(minl);
    len = 16'(pdu + 1);
    tid = mode_client ? gen_tid : 16'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      queue_frame(tid, 16'h0000, len, 8'($urandom), HEADER_BYTES + pdu, 1'b1);
    end else if (sel < 55) begin
      if (mode_client) tid = gen_tid - 16'(pick_offset(16'h7FFF));
      queue_frame(tid, 16'h0000, len, 8'($urandom), HEADER_BYTES + pdu, 1'b1);
    end else if (sel < 60) begin
      if (mode_client) tid = gen_tid + 16'(pick_offset(16'h8000));
      n = mode_client ? HEADER_BYTES : HEADER_BYTES + pdu;
      queue_frame(tid, 16'h0000, len, 8'($urandom), n, 1'b0);
    end else if (sel < 65) begin
      queue_frame(16'($urandom), 16'($urandom_range(1, 16'hFFFF)), len, 8'($urandom),
                  HEADER_BYTES, 1'b0);
    end else if (sel < 72) begin
      case ($urandom_range(0, 3))
        0: len = 16'd0;
        1: len = 16'($urandom_range(0, minl));
        2: len = 16'(PDU_LIMIT + 2);
        default: len = 16'($urandom_range(PDU_LIMIT + 2, 16'hFFFF));
      endcase
      queue_frame(16'($urandom), 16'h0000, len, 8'($urandom), HEADER_BYTES, 1'b0);
    end else if (sel < 80) begin
      // Cut a frame short anywhere, header or PDU, and end the link.
      if (mode_client && $urandom_range(0, 2) == 0)
        tid = gen_tid - 16'(pick_offset(16'h7FFF));
      n = $urandom_range(1, HEADER_BYTES + pdu - 1);
      queue_frame(tid, 16'h0000, len, 8'($urandom), n, 1'b1);
      push_item(link_event(), 8'($urandom));
    end else if (sel < 87) begin
      push_item(CMD_REQUEST, 8'($urandom));
    end else if (sel < 93) begin
      push_item(link_event(), 8'($urandom));
    end else begin
      // Garbage, closed by a link event so the next frame starts clean.
      n = $urandom_range(1, 12);
      repeat (n) begin
        if ($urandom_range(0, 3) != 0) push_item(CMD_BYTE, 8'($urandom));
        else push_item(cmd_t'($urandom_range(1, 3)), 8'($urandom));
      end
      push_item(link_event(), 8'($urandom));
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (cmd_fifo.size() != 0 || in_valid || owed_reports.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_CLIENT_MODE:  mode_client = val[0];
      REG_MIN_RESP_LEN: min_resp = val;
      REG_MIN_REQ_LEN:  min_req = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Must start with the receiver idle. Halfway through, the sender holds off
  // until every owed report has come back.
  task automatic run_phase(input int n_items);
    int stop_at;
    int pause_at;
    gen_tid = cur_tid;
    stop_at = queued_items + n_items;
    pause_at = queued_items + n_items / 2;
    while (queued_items < stop_at) begin
      queue_random_burst();
      if (pause_at > 0 && queued_items >= pause_at) begin
        wait_idle();
        pause_at = 0;
      end
    end
    wait_idle();
    phases_run++;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: client mode, transaction id zero, minimum response two.
    push_item(CMD_TIMEOUT, 8'h00);
    push_item(CMD_CLOSE, 8'hFF);
    push_item(CMD_REQUEST, 8'h5A);
    queue_frame(16'd1, 16'h0000, 16'd3, 8'hFF, 9, 1'b0);
    queue_frame(16'd1, 16'hFFFF, 16'd3, 8'h00, 7, 1'b0);
    queue_frame(16'd1, 16'h0000, 16'd2, 8'h11, 7, 1'b0);
    // Ids half a range ahead are unknown; one more than that is stale.
    queue_frame(16'h8001, 16'h0000, 16'd3, 8'h22, 7, 1'b0);
    queue_frame(16'h8002, 16'h0000, 16'd3, 8'h33, 9, 1'b0);
    queue_frame(16'd1, 16'h0000, 16'd3, 8'h44, 3, 1'b0);
    push_item(CMD_CLOSE, 8'h81);
    queue_frame(16'd1, 16'h0000, 16'd3, 8'h55, 8, 1'b0);
    push_item(CMD_TIMEOUT, 8'h7E);
    wait_idle();
    run_phase(250);

    write_reg(REG_MIN_RESP_LEN, 8'd1);
    write_reg(REG_MIN_REQ_LEN, 8'd253);
    run_phase(300);

    write_reg(REG_CLIENT_MODE, 8'd0);
    // A server ignores requests.
    push_item(CMD_REQUEST, 8'($urandom));
    run_phase(250);

    write_reg(REG_MIN_REQ_LEN, 8'd1);
    run_phase(250);

    write_reg(REG_CLIENT_MODE, 8'd1);
    write_reg(REG_MIN_RESP_LEN, 8'd253);
    run_phase(150);

    write_reg(REG_MIN_RESP_LEN, 8'($urandom_range(1, 16)));
    run_phase(200);

    write_reg(REG_CLIENT_MODE, 8'd0);
    write_reg(REG_MIN_REQ_LEN, 8'($urandom_range(2, 16)));
    run_phase(200);

    repeat (8) @(negedge clk);
    $display("Sent %0d commands over %0d setting phases in client and server mode.",
             cmds_sent, phases_run);
    $display("Checked %0d reports: %0d PDU bytes in %0d frames, %0d events, %0d rejects.",
             results_checked, status_seen[ST_PDU_BYTE], frames_done,
             status_seen[ST_REQ_ISSUED] + status_seen[ST_TIMEOUT_IDLE]
               + status_seen[ST_CLOSED_IDLE] + status_seen[ST_BROKEN_FRAME],
             status_seen[ST_BAD_PROTOCOL] + status_seen[ST_BAD_LENGTH]
               + status_seen[ST_UNKNOWN_TID]);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
